>>> rtl/gpio_irq_slot_allocator_top_macros.svh
// Assertion macros shared by the GPIO interrupt slot allocator.
`ifndef GPIO_IRQ_SLOT_ALLOCATOR_TOP_MACROS_SVH
`define GPIO_IRQ_SLOT_ALLOCATOR_TOP_MACROS_SVH

// The antecedent implies the consequent in the same cycle.
`define GIA_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The antecedent implies the consequent in the next cycle.
`define GIA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/gia_pkg.sv
// Package with types, codes and constants of the GPIO interrupt slot allocator.
package gia_pkg;

    localparam int GIA_MAX_SLOTS = 8;
    localparam int GIA_MAX_PIN   = 255;

    localparam int MASK_W   = 8;
    localparam int SLOT_W   = 3;
    localparam int PIN_IN_W = 10;
    localparam int PIN_W    = 9;
    localparam int CNT_W    = 4;

    localparam logic [PIN_W-1:0] PIN_EMPTY = 9'd256;

    typedef enum logic [1:0] {
        OP_ALLOC   = 2'd0,
        OP_RELEASE = 2'd1,
        OP_SET_POL = 2'd2,
        OP_RSVD    = 2'd3
    } t_opcode;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_INVALID   = 3'd1,
        ST_NO_SLOT   = 3'd2,
        ST_EXISTS    = 3'd3,
        ST_NOT_FOUND = 3'd4
    } t_status;

    localparam logic [2:0] MODE_EDGE_HIGH  = 3'd0;
    localparam logic [2:0] MODE_EDGE_LOW   = 3'd1;
    localparam logic [2:0] MODE_LEVEL_HIGH = 3'd2;
    localparam logic [2:0] MODE_LEVEL_LOW  = 3'd3;

    localparam logic POL_ACTIVE_HIGH = 1'b1;

    typedef struct packed {
        logic [1:0]          opcode;
        logic [PIN_IN_W-1:0] pin;
        logic [2:0]          mode;
        logic                polarity;
    } t_in_beat;

    typedef struct packed {
        logic [2:0]        status;
        logic [SLOT_W-1:0] slot;
        logic [MASK_W-1:0] edge_mask;
        logic [MASK_W-1:0] active_low_mask;
    } t_out_beat;

    typedef struct packed {
        logic load;
        logic commit;
    } t_dp_cmd;

    typedef struct packed {
        logic out_free;
    } t_dp_status;

    typedef enum logic [0:0] {
        CS_IDLE = 1'b0,
        CS_EXEC = 1'b1
    } t_ctrl_state;

endpackage

>>> rtl/gia_ctrl.sv
// Controller state machine that sequences beat capture and execution.
module gia_ctrl
    import gia_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  t_dp_status i_status,
    output logic       o_in_ready,
    output t_dp_cmd    o_cmd,
    output logic       o_busy
);

    t_ctrl_state r_state;
    t_ctrl_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= CS_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            CS_IDLE: begin
                if (i_in_valid) begin
                    n_state = CS_EXEC;
                end
            end
            CS_EXEC: begin
                if (i_status.out_free && !i_in_valid) begin
                    n_state = CS_IDLE;
                end
            end
            default: n_state = CS_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready   = 1'b0;
        o_cmd.commit = 1'b0;
        o_busy       = 1'b0;
        unique case (r_state)
            CS_IDLE: begin
                o_in_ready = 1'b1;
            end
            CS_EXEC: begin
                o_busy       = 1'b1;
                o_cmd.commit = i_status.out_free;
                o_in_ready   = i_status.out_free;
            end
            default: o_in_ready = 1'b0;
        endcase
        o_cmd.load = i_in_valid && o_in_ready;
    end

endmodule

>>> rtl/gia_datapath.sv
// Datapath with the slot table, search logic and the output register.
module gia_datapath
    import gia_pkg::*;
#(
    parameter int MAX_SLOTS = GIA_MAX_SLOTS,
    parameter int MAX_PIN   = GIA_MAX_PIN
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [CNT_W-1:0] i_cfg_wdata,
    input  t_in_beat         i_in_beat,
    input  logic             i_out_ready,
    input  t_dp_cmd          i_cmd,
    output t_dp_status       o_status,
    output logic             o_out_valid,
    output t_out_beat        o_out_beat
);

    logic [CNT_W-1:0]  r_slot_count;
    t_in_beat          r_beat;
    logic [MASK_W-1:0] r_used;
    logic [MASK_W-1:0] r_edge;
    logic [MASK_W-1:0] r_low;
    logic [PIN_W-1:0]  r_slot_pin [MAX_SLOTS];
    logic              r_out_valid;
    t_out_beat         r_out_beat;

    logic [MASK_W-1:0] n_used;
    logic [MASK_W-1:0] n_edge;
    logic [MASK_W-1:0] n_low;
    logic [PIN_W-1:0]  n_slot_pin [MAX_SLOTS];
    t_out_beat         n_out_beat;

    logic [CNT_W-1:0]  usable;
    logic [MASK_W-1:0] free_vec;
    logic [MASK_W-1:0] hit_vec;
    logic [MASK_W-1:0] free_sel;
    logic [MASK_W-1:0] hit_sel;
    logic [SLOT_W-1:0] free_idx;
    logic [SLOT_W-1:0] hit_idx;
    logic              pin_ok;
    logic              mode_edge;
    logic              mode_low;

    assign usable = (r_slot_count > CNT_W'(MAX_SLOTS)) ? CNT_W'(MAX_SLOTS) : r_slot_count;
    assign pin_ok = r_beat.pin <= PIN_IN_W'(MAX_PIN);
    assign mode_edge = (r_beat.mode == MODE_EDGE_HIGH) || (r_beat.mode == MODE_EDGE_LOW);
    assign mode_low  = (r_beat.mode == MODE_EDGE_LOW) || (r_beat.mode == MODE_LEVEL_LOW);

    always_comb begin
        free_vec = '0;
        hit_vec  = '0;
        for (int i = 0; i < MAX_SLOTS; i++) begin
            free_vec[i] = (CNT_W'(i) < usable) && !r_used[i];
            hit_vec[i]  = (CNT_W'(i) < usable) && (r_slot_pin[i] == r_beat.pin[PIN_W-1:0]);
        end
    end

    always_comb begin
        free_sel = '0;
        hit_sel  = '0;
        free_idx = '0;
        hit_idx  = '0;
        for (int i = MAX_SLOTS - 1; i >= 0; i--) begin
            if (free_vec[i]) begin
                free_sel    = '0;
                free_sel[i] = 1'b1;
                free_idx    = SLOT_W'(i);
            end
            if (hit_vec[i]) begin
                hit_sel    = '0;
                hit_sel[i] = 1'b1;
                hit_idx    = SLOT_W'(i);
            end
        end
    end

    always_comb begin
        n_used = r_used;
        n_edge = r_edge;
        n_low  = r_low;
        for (int i = 0; i < MAX_SLOTS; i++) begin
            n_slot_pin[i] = r_slot_pin[i];
        end
        n_out_beat.status = ST_INVALID;
        n_out_beat.slot   = '0;
        unique case (r_beat.opcode)
            OP_ALLOC: begin
                if (!pin_ok) begin
                    n_out_beat.status = ST_INVALID;
                end else if (free_vec == '0) begin
                    n_out_beat.status = ST_NO_SLOT;
                end else if (hit_vec != '0) begin
                    n_out_beat.status = ST_EXISTS;
                end else if (r_beat.mode > MODE_LEVEL_LOW) begin
                    n_out_beat.status = ST_INVALID;
                end else begin
                    n_out_beat.status = ST_OK;
                    n_out_beat.slot   = free_idx;
                    n_used = r_used | free_sel;
                    n_edge = mode_edge ? (r_edge | free_sel) : (r_edge & ~free_sel);
                    n_low  = mode_low ? (r_low | free_sel) : (r_low & ~free_sel);
                    for (int i = 0; i < MAX_SLOTS; i++) begin
                        if (free_sel[i]) begin
                            n_slot_pin[i] = r_beat.pin[PIN_W-1:0];
                        end
                    end
                end
            end
            OP_RELEASE: begin
                if (!pin_ok || hit_vec == '0) begin
                    n_out_beat.status = ST_NOT_FOUND;
                end else begin
                    n_out_beat.status = ST_OK;
                    n_out_beat.slot   = hit_idx;
                    n_used = r_used & ~hit_sel;
                    for (int i = 0; i < MAX_SLOTS; i++) begin
                        if (hit_sel[i]) begin
                            n_slot_pin[i] = PIN_EMPTY;
                        end
                    end
                end
            end
            OP_SET_POL: begin
                if (!pin_ok) begin
                    n_out_beat.status = ST_INVALID;
                end else if (hit_vec == '0) begin
                    n_out_beat.status = ST_NOT_FOUND;
                end else begin
                    n_out_beat.status = ST_OK;
                    n_out_beat.slot   = hit_idx;
                    n_low = (r_beat.polarity == POL_ACTIVE_HIGH) ?
                            (r_low & ~hit_sel) : (r_low | hit_sel);
                end
            end
            default: n_out_beat.status = ST_INVALID;
        endcase
        n_out_beat.edge_mask       = n_edge;
        n_out_beat.active_low_mask = n_low;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot_count <= CNT_W'(GIA_MAX_SLOTS);
            r_used       <= '0;
            r_edge       <= '0;
            r_low        <= '0;
            r_out_valid  <= 1'b0;
            for (int i = 0; i < MAX_SLOTS; i++) begin
                r_slot_pin[i] <= PIN_EMPTY;
            end
        end else begin
            if (i_cfg_we) begin
                r_slot_count <= i_cfg_wdata;
            end
            if (i_cmd.commit) begin
                r_used      <= n_used;
                r_edge      <= n_edge;
                r_low       <= n_low;
                r_out_valid <= 1'b1;
                for (int i = 0; i < MAX_SLOTS; i++) begin
                    r_slot_pin[i] <= n_slot_pin[i];
                end
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_beat <= i_in_beat;
        end
        if (i_cmd.commit) begin
            r_out_beat <= n_out_beat;
        end
    end

    assign o_status.out_free = !r_out_valid || i_out_ready;
    assign o_out_valid       = r_out_valid;
    assign o_out_beat        = r_out_beat;

endmodule

>>> rtl/gpio_irq_slot_allocator_top.sv
// GPIO interrupt slot allocator: each request beat (allocate, release or set
// polarity) yields exactly one result beat with a status, the slot concerned and
// the per-slot edge and active-low masks after the request. A request is
// captured in the request register and then executed against the slot table,
// with the result going to the single output register once that is free; a new
// request is taken every cycle as long as the output register drains. The slot
// count is clamped to MAX_SLOTS where it is used, and only slots below the
// clamped count are searched or allocated.
`include "gpio_irq_slot_allocator_top_macros.svh"

module gpio_irq_slot_allocator_top
    import gia_pkg::*;
#(
    parameter int MAX_SLOTS = GIA_MAX_SLOTS,
    parameter int MAX_PIN   = GIA_MAX_PIN
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [CNT_W-1:0] i_cfg_wdata,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  t_in_beat         i_in_beat,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output t_out_beat        o_out_beat
);

    t_dp_cmd    w_cmd;
    t_dp_status w_status;
    logic       w_busy;

    gia_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_status   (w_status),
        .o_in_ready (o_in_ready),
        .o_cmd      (w_cmd),
        .o_busy     (w_busy)
    );

    gia_datapath #(
        .MAX_SLOTS (MAX_SLOTS),
        .MAX_PIN   (MAX_PIN)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_beat   (i_in_beat),
        .i_out_ready (i_out_ready),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .o_out_valid (o_out_valid),
        .o_out_beat  (o_out_beat)
    );

    `GIA_ASSERT_NOW(a_err_slot_zero, i_clk, i_rst_n,
        o_out_valid && o_out_beat.status != ST_OK, o_out_beat.slot == '0,
        "failed request reports a nonzero slot")
    `GIA_ASSERT_NOW(a_commit_only_busy, i_clk, i_rst_n,
        w_cmd.commit, w_busy && (!o_out_valid || i_out_ready),
        "execution while idle or while the output register is blocked")
    `GIA_ASSERT_NEXT(a_commit_shows, i_clk, i_rst_n,
        w_cmd.commit, o_out_valid,
        "executed request did not reach the output register")
    `GIA_ASSERT_NOW(a_status_range, i_clk, i_rst_n,
        o_out_valid, o_out_beat.status <= ST_NOT_FOUND,
        "result beat carries an undefined status code")

endmodule
